[hw/rtl/qsa_pkg.sv]
package qsa_pkg;

	localparam int POOL_SIZE = 2048;
	localparam int HANDLE_W  = $clog2(POOL_SIZE);
	localparam int SLOT_W    = $clog2(POOL_SIZE);
	localparam int CNT_W     = $clog2(POOL_SIZE + 1);
	localparam int CFG_W     = 12;
	localparam int FRAG_W    = 32;
	localparam int WORD_W    = 32;
	localparam int BIT_W     = $clog2(WORD_W);
	localparam int ROWS      = POOL_SIZE / WORD_W;
	localparam int ROW_W     = $clog2(ROWS);
	localparam int CHUNKS    = ROWS / WORD_W;
	localparam int CHUNK_W   = $clog2(CHUNKS);

	localparam logic [1:0] CMD_BEGIN = 2'd0;
	localparam logic [1:0] CMD_END   = 2'd1;
	localparam logic [1:0] CMD_GET   = 2'd2;

	localparam logic [1:0] OUTCOME_READY = 2'd0;

	localparam logic CFG_ENABLED    = 1'b0;
	localparam logic CFG_SLOT_LIMIT = 1'b1;

	localparam logic [FRAG_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_DISABLED   = 3'd1,
		ST_NO_SLOT    = 3'd2,
		ST_INVALID    = 3'd3,
		ST_NOT_IN_USE = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_BRD,
		S_BHU,
		S_HCHK,
		S_GWR,
		S_RESP
	} state_t;

	// lowest set bit: {found, index}
	function automatic logic [BIT_W:0] ffs_word(input logic [WORD_W-1:0] v);
		logic [BIT_W:0] r;
		r = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = {1'b1, BIT_W'(i)};
			end
		end
		return r;
	endfunction

endpackage

[hw/rtl/query_slot_allocator_top.sv]
// Occlusion-query slot allocator.
// Input channel (in_valid/in_stall) carries one command per transfer: begin,
// end or get. Output channel (out_valid/out_stall) returns one result per
// command, in order. Config channel (cfg_valid/cfg_ready, always ready)
// writes enabled (index 0) and slot_limit (index 1); the user must write
// them only while the block is idle; the block itself does not enforce it.
// Commands are worked one at a time; in_stall is high while one is in flight.
// The result turns valid in the same cycle as in_stall drops for the next
// command. Begin runs the shared find-first-set unit over the free-slot
// summary one 32-bit chunk a cycle, then over the chosen bitmap row; the
// row step waits on a registered RAM read.
// Results sit in an output register: a new command is taken while the last
// result is still stalled, but its own result waits until that one moves.
// Reset: all slots free, no handle in use, empty handle stack, enabled,
// slot_limit 2048. Bitmap rows carry written flags, so no clearing pass.
module query_slot_allocator_top import qsa_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          cmd,
	input  logic [HANDLE_W-1:0] handle,
	input  logic                handle_valid,
	input  logic [FRAG_W-1:0]   query_count,
	input  logic [1:0]          query_outcome,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [2:0]          status,
	output logic [HANDLE_W-1:0] out_handle,
	output logic                out_handle_valid,
	output logic [SLOT_W-1:0]   slot,
	output logic [FRAG_W-1:0]   fragments,
	output logic                culled,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [CFG_W-1:0]    cfg_data
);

	state_t state_q, state_d;

	logic             enabled_q;
	logic [CFG_W-1:0] slot_limit_q;

	logic [1:0]          cmd_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [FRAG_W-1:0]   count_q;
	logic [1:0]          outcome_q;

	status_t             st_q, st_d;
	logic                st_we;
	logic [SLOT_W-1:0]   s_q, s_d;
	logic                s_we;
	logic [HANDLE_W-1:0] h_q, h_d;
	logic                h_we;
	logic [CHUNK_W-1:0]  chunk_q, chunk_d;

	logic [CNT_W-1:0] free_count_q, hw_q, cnt_m1, lim;
	logic             cnt_inc, cnt_dec, hw_inc;

	logic [ROWS-1:0]  summary_q;
	logic             sum_we, sum_val;
	logic [ROW_W-1:0] sum_row;

	logic              map_rd_en, map_wr_en;
	logic [ROW_W-1:0]  map_rd_row, map_wr_row;
	logic [WORD_W-1:0] map_rd_word, map_wr_word, map_new_word;

	logic              idle_rd_en, idle_wr_en;
	logic [ROW_W-1:0]  idle_rd_row, idle_wr_row;
	logic [WORD_W-1:0] idle_rd_word, idle_wr_word;

	logic                tbl_rd_en, tbl_wr_en;
	logic [HANDLE_W-1:0] tbl_rd_addr, tbl_wr_addr;
	logic [SLOT_W-1:0]   tbl_rd_data, tbl_wr_data;

	logic                stk_rd_en, stk_wr_en;
	logic [HANDLE_W-1:0] stk_rd_addr, stk_wr_addr;
	logic [HANDLE_W-1:0] stk_rd_data, stk_wr_data;

	logic [WORD_W-1:0] ffs_in;
	logic [BIT_W:0]    ffs_out;
	logic [SLOT_W-1:0] new_slot;

	logic              out_load;
	logic              accept;
	logic [FRAG_W-1:0] get_frag;

	logic                out_valid_q, out_hv_q, culled_q;
	logic [2:0]          status_q;
	logic [HANDLE_W-1:0] out_handle_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [FRAG_W-1:0]   frag_q;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign cnt_m1    = free_count_q - 1'b1;
	assign lim       = (slot_limit_q > CNT_W'(POOL_SIZE)) ? CNT_W'(POOL_SIZE) : slot_limit_q;

	qsa_bitmap u_slot_map (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (map_rd_en),
		.rd_row (map_rd_row),
		.rd_word(map_rd_word),
		.wr_en  (map_wr_en),
		.wr_row (map_wr_row),
		.wr_word(map_wr_word)
	);

	// one bit per handle, set while the handle is not in use
	qsa_bitmap u_handle_idle (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (idle_rd_en),
		.rd_row (idle_rd_row),
		.rd_word(idle_rd_word),
		.wr_en  (idle_wr_en),
		.wr_row (idle_wr_row),
		.wr_word(idle_wr_word)
	);

	qsa_ram #(
		.DEPTH(POOL_SIZE),
		.WIDTH(SLOT_W)
	) u_slot_table (
		.clk    (clk),
		.wr_en  (tbl_wr_en),
		.wr_addr(tbl_wr_addr),
		.wr_data(tbl_wr_data),
		.rd_en  (tbl_rd_en),
		.rd_addr(tbl_rd_addr),
		.rd_data(tbl_rd_data)
	);

	qsa_ram #(
		.DEPTH(POOL_SIZE),
		.WIDTH(HANDLE_W)
	) u_handle_stack (
		.clk    (clk),
		.wr_en  (stk_wr_en),
		.wr_addr(stk_wr_addr),
		.wr_data(stk_wr_data),
		.rd_en  (stk_rd_en),
		.rd_addr(stk_rd_addr),
		.rd_data(stk_rd_data)
	);

	// shared find-first-set unit
	assign ffs_in   = (state_q == S_BRD) ? map_rd_word
	                                     : summary_q[{chunk_q, BIT_W'(0)} +: WORD_W];
	assign ffs_out  = ffs_word(ffs_in);
	assign new_slot = {s_q[SLOT_W-1:BIT_W], ffs_out[BIT_W-1:0]};
	assign map_new_word = map_rd_word & ~(WORD_W'(1) << ffs_out[BIT_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		st_we        = 1'b0;
		st_d         = ST_OK;
		s_we         = 1'b0;
		s_d          = '0;
		h_we         = 1'b0;
		h_d          = '0;
		chunk_d      = chunk_q;
		cnt_inc      = 1'b0;
		cnt_dec      = 1'b0;
		hw_inc       = 1'b0;
		sum_we       = 1'b0;
		sum_row      = '0;
		sum_val      = 1'b0;
		map_rd_en    = 1'b0;
		map_rd_row   = '0;
		map_wr_en    = 1'b0;
		map_wr_row   = '0;
		map_wr_word  = '0;
		idle_rd_en   = 1'b0;
		idle_rd_row  = '0;
		idle_wr_en   = 1'b0;
		idle_wr_row  = '0;
		idle_wr_word = '0;
		tbl_rd_en    = 1'b0;
		tbl_rd_addr  = '0;
		tbl_wr_en    = 1'b0;
		tbl_wr_addr  = '0;
		tbl_wr_data  = '0;
		stk_rd_en    = 1'b0;
		stk_rd_addr  = '0;
		stk_wr_en    = 1'b0;
		stk_wr_addr  = '0;
		stk_wr_data  = '0;
		out_load     = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					st_we   = 1'b1;
					state_d = S_RESP;
					unique case (cmd)
						CMD_BEGIN: begin
							priority if (!enabled_q) begin
								st_d = ST_DISABLED;
							end else if (free_count_q == '0 && hw_q >= CNT_W'(POOL_SIZE)) begin
								st_d = ST_NO_SLOT;
							end else begin
								st_we       = 1'b0;
								chunk_d     = '0;
								stk_rd_en   = (free_count_q != '0);
								stk_rd_addr = cnt_m1[HANDLE_W-1:0];
								state_d     = S_SCAN;
							end
						end
						CMD_END, CMD_GET: begin
							priority if (!enabled_q) begin
								st_d = ST_DISABLED;
							end else if (!handle_valid
							             || CNT_W'(handle) >= CNT_W'(POOL_SIZE)) begin
								st_d = ST_INVALID;
							end else begin
								st_we       = 1'b0;
								idle_rd_en  = 1'b1;
								idle_rd_row = handle[HANDLE_W-1:BIT_W];
								tbl_rd_en   = 1'b1;
								tbl_rd_addr = handle;
								state_d     = S_HCHK;
							end
						end
						default: begin
							st_d = ST_OK;
						end
					endcase
				end
			end
			S_SCAN: begin
				priority if (ffs_out[BIT_W]) begin
					map_rd_en  = 1'b1;
					map_rd_row = {chunk_q, ffs_out[BIT_W-1:0]};
					s_we       = 1'b1;
					s_d        = {chunk_q, ffs_out[BIT_W-1:0], BIT_W'(0)};
					state_d    = S_BRD;
				end else if (chunk_q == CHUNK_W'(CHUNKS - 1)) begin
					st_we   = 1'b1;
					st_d    = ST_NO_SLOT;
					state_d = S_RESP;
				end else begin
					chunk_d = chunk_q + 1'b1;
				end
			end
			S_BRD: begin
				if (CNT_W'(new_slot) >= lim) begin
					st_we   = 1'b1;
					st_d    = ST_NO_SLOT;
					state_d = S_RESP;
				end else begin
					s_we        = 1'b1;
					s_d         = new_slot;
					map_wr_en   = 1'b1;
					map_wr_row  = new_slot[SLOT_W-1:BIT_W];
					map_wr_word = map_new_word;
					sum_we      = 1'b1;
					sum_row     = new_slot[SLOT_W-1:BIT_W];
					sum_val     = |map_new_word;
					h_we        = 1'b1;
					if (free_count_q != '0) begin
						h_d     = stk_rd_data;
						cnt_dec = 1'b1;
					end else begin
						h_d    = hw_q[HANDLE_W-1:0];
						hw_inc = 1'b1;
					end
					idle_rd_en  = 1'b1;
					idle_rd_row = h_d[HANDLE_W-1:BIT_W];
					state_d     = S_BHU;
				end
			end
			S_BHU: begin
				idle_wr_en   = 1'b1;
				idle_wr_row  = h_q[HANDLE_W-1:BIT_W];
				idle_wr_word = idle_rd_word & ~(WORD_W'(1) << h_q[BIT_W-1:0]);
				tbl_wr_en    = 1'b1;
				tbl_wr_addr  = h_q;
				tbl_wr_data  = s_q;
				st_we        = 1'b1;
				st_d         = ST_OK;
				state_d      = S_RESP;
			end
			S_HCHK: begin
				st_we   = 1'b1;
				state_d = S_RESP;
				if (idle_rd_word[handle_q[BIT_W-1:0]]) begin
					st_d = ST_NOT_IN_USE;
				end else begin
					st_d = ST_OK;
					s_we = 1'b1;
					s_d  = tbl_rd_data;
					if (cmd_q == CMD_GET) begin
						idle_wr_en   = 1'b1;
						idle_wr_row  = handle_q[HANDLE_W-1:BIT_W];
						idle_wr_word = idle_rd_word | (WORD_W'(1) << handle_q[BIT_W-1:0]);
						map_rd_en    = 1'b1;
						map_rd_row   = tbl_rd_data[SLOT_W-1:BIT_W];
						if (free_count_q < CNT_W'(POOL_SIZE)) begin
							stk_wr_en   = 1'b1;
							stk_wr_addr = free_count_q[HANDLE_W-1:0];
							stk_wr_data = handle_q;
							cnt_inc     = 1'b1;
						end
						state_d = S_GWR;
					end
				end
			end
			S_GWR: begin
				map_wr_en   = 1'b1;
				map_wr_row  = s_q[SLOT_W-1:BIT_W];
				map_wr_word = map_rd_word | (WORD_W'(1) << s_q[BIT_W-1:0]);
				sum_we      = 1'b1;
				sum_row     = s_q[SLOT_W-1:BIT_W];
				sum_val     = 1'b1;
				state_d     = S_RESP;
			end
			S_RESP: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q    <= 1'b1;
			slot_limit_q <= CFG_W'(POOL_SIZE);
			free_count_q <= '0;
			hw_q         <= '0;
			summary_q    <= '1;
			chunk_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_ENABLED:    enabled_q    <= cfg_data[0];
					CFG_SLOT_LIMIT: slot_limit_q <= cfg_data;
					default:        enabled_q    <= enabled_q;
				endcase
			end
			if (cnt_inc) begin
				free_count_q <= free_count_q + 1'b1;
			end else if (cnt_dec) begin
				free_count_q <= cnt_m1;
			end
			if (hw_inc) begin
				hw_q <= hw_q + 1'b1;
			end
			if (sum_we) begin
				summary_q[sum_row] <= sum_val;
			end
			chunk_q <= chunk_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q     <= cmd;
			handle_q  <= handle;
			count_q   <= query_count;
			outcome_q <= query_outcome;
		end
		if (st_we) begin
			st_q <= st_d;
		end
		if (s_we) begin
			s_q <= s_d;
		end
		if (h_we) begin
			h_q <= h_d;
		end
	end

	assign get_frag = (outcome_q == OUTCOME_READY) ? count_q : ALL_ONES;

	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q     <= st_q;
			out_handle_q <= '0;
			out_hv_q     <= 1'b0;
			slot_q       <= '0;
			frag_q       <= '0;
			culled_q     <= 1'b0;
			if (st_q == ST_OK) begin
				unique case (cmd_q)
					CMD_BEGIN: begin
						out_handle_q <= h_q;
						out_hv_q     <= 1'b1;
						slot_q       <= s_q;
					end
					CMD_END: begin
						slot_q <= s_q;
					end
					CMD_GET: begin
						slot_q   <= s_q;
						frag_q   <= get_frag;
						culled_q <= (get_frag == '0);
					end
					default: begin
						slot_q <= '0;
					end
				endcase
			end else if (cmd_q == CMD_GET) begin
				frag_q <= ALL_ONES;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = status_q;
	assign out_handle       = out_handle_q;
	assign out_handle_valid = out_hv_q;
	assign slot             = slot_q;
	assign fragments        = frag_q;
	assign culled           = culled_q;

endmodule

[hw/rtl/qsa_ram.sv]
module qsa_ram #(
	parameter int DEPTH = 2048,
	parameter int WIDTH = 11
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[hw/rtl/qsa_bitmap.sv]
module qsa_bitmap import qsa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [ROW_W-1:0]  rd_row,
	output logic [WORD_W-1:0] rd_word,
	input  logic              wr_en,
	input  logic [ROW_W-1:0]  wr_row,
	input  logic [WORD_W-1:0] wr_word
);

	// rows never written read as all ones
	logic [ROWS-1:0]   row_written_q;
	logic              rd_written_q;
	logic [WORD_W-1:0] ram_word;

	qsa_ram #(
		.DEPTH(ROWS),
		.WIDTH(WORD_W)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_row),
		.wr_data(wr_word),
		.rd_en  (rd_en),
		.rd_addr(rd_row),
		.rd_data(ram_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_written_q <= '0;
			rd_written_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				row_written_q[wr_row] <= 1'b1;
			end
			if (rd_en) begin
				rd_written_q <= row_written_q[rd_row];
			end
		end
	end

	assign rd_word = rd_written_q ? ram_word : '1;

endmodule

[dv/query_slot_allocator_chk.sv]
module query_slot_allocator_chk import qsa_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic [1:0]          cmd,
	input  logic [HANDLE_W-1:0] handle,
	input  logic                handle_valid,
	input  logic [FRAG_W-1:0]   query_count,
	input  logic [1:0]          query_outcome,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic [2:0]          status,
	input  logic [HANDLE_W-1:0] out_handle,
	input  logic                out_handle_valid,
	input  logic [SLOT_W-1:0]   slot,
	input  logic [FRAG_W-1:0]   fragments,
	input  logic                culled,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [CFG_W-1:0]    cfg_data,
	output int                  fail_count,
	output int                  replies_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [2:0]          status;
		logic [HANDLE_W-1:0] hdl;
		logic                hdl_ok;
		logic [SLOT_W-1:0]   slot;
		logic [FRAG_W-1:0]   frags;
		logic                culled;
	} reply_t;

	bit                  slot_free [POOL_SIZE];
	logic [SLOT_W-1:0]   slot_of   [POOL_SIZE];
	bit                  live      [POOL_SIZE];
	logic [HANDLE_W-1:0] spare     [POOL_SIZE];
	int                  spare_cnt;
	int                  minted;
	logic                en;
	logic [CFG_W-1:0]    limit;
	reply_t              replies_due [$];
	int                  fails = 0;
	int                  n_due = 0;
	int                  n_out = 0;

	assign fail_count      = fails;
	assign replies_pending = n_due;

	task automatic report(input string what, input logic [FRAG_W-1:0] got,
			input logic [FRAG_W-1:0] want);
		fails++;
		$display("%0t mismatch %s on result %0d: got %0h want %0h",
			$time, what, n_out, got, want);
	endtask

	// one command against the shadow tables; updates them as the block would
	function automatic reply_t resolve_cmd(input logic [1:0] c,
			input logic [HANDLE_W-1:0] h, input logic hv,
			input logic [FRAG_W-1:0] cnt, input logic [1:0] oc);
		reply_t              r;
		int                  lim;
		int                  s;
		logic [HANDLE_W-1:0] nh;
		logic [FRAG_W-1:0]   f;
		r = '0;
		if (c != CMD_BEGIN && c != CMD_END && c != CMD_GET) begin
			return r;
		end
		if (!en) begin
			r.status = ST_DISABLED;
			if (c == CMD_GET) begin
				r.frags = ALL_ONES;
			end
			return r;
		end
		if (c == CMD_BEGIN) begin
			lim = (limit < POOL_SIZE) ? int'(limit) : POOL_SIZE;
			s = 0;
			while (s < lim && !slot_free[s]) begin
				s++;
			end
			if (s >= lim || (spare_cnt == 0 && minted >= POOL_SIZE)) begin
				r.status = ST_NO_SLOT;
				return r;
			end
			if (spare_cnt > 0) begin
				spare_cnt--;
				nh = spare[spare_cnt];
			end else begin
				nh = HANDLE_W'(minted);
				minted++;
			end
			slot_free[s] = 1'b0;
			slot_of[nh]  = SLOT_W'(s);
			live[nh]     = 1'b1;
			r.status = ST_OK;
			r.hdl    = nh;
			r.hdl_ok = 1'b1;
			r.slot   = SLOT_W'(s);
			return r;
		end
		if (!hv) begin
			r.status = ST_INVALID;
			if (c == CMD_GET) begin
				r.frags = ALL_ONES;
			end
			return r;
		end
		if (!live[h]) begin
			r.status = ST_NOT_IN_USE;
			if (c == CMD_GET) begin
				r.frags = ALL_ONES;
			end
			return r;
		end
		r.status = ST_OK;
		r.slot   = slot_of[h];
		if (c == CMD_END) begin
			return r;
		end
		f = (oc == OUTCOME_READY) ? cnt : ALL_ONES;
		slot_free[slot_of[h]] = 1'b1;
		live[h] = 1'b0;
		if (spare_cnt < POOL_SIZE) begin
			spare[spare_cnt] = h;
			spare_cnt++;
		end
		r.frags  = f;
		r.culled = (f == '0);
		return r;
	endfunction

	always @(posedge clk) begin : watch
		reply_t got;
		reply_t want;
		if (!arst_n) begin
			for (int i = 0; i < POOL_SIZE; i++) begin
				slot_free[i] = 1'b1;
				slot_of[i]   = '0;
				live[i]      = 1'b0;
				spare[i]     = '0;
			end
			spare_cnt = 0;
			minted    = 0;
			en        = 1'b1;
			limit     = CFG_W'(POOL_SIZE);
			replies_due.delete();
		end else begin
			if (out_valid && !out_stall) begin
				got = {status, out_handle, out_handle_valid, slot, fragments, culled};
				n_out++;
				if (replies_due.size() == 0) begin
					report("result with nothing due", got.frags, '0);
				end else begin
					want = replies_due.pop_front();
					if (got.status !== want.status)
						report("status", got.status, want.status);
					if (got.hdl !== want.hdl)
						report("out_handle", got.hdl, want.hdl);
					if (got.hdl_ok !== want.hdl_ok)
						report("out_handle_valid", got.hdl_ok, want.hdl_ok);
					if (got.slot !== want.slot)
						report("slot", got.slot, want.slot);
					if (got.frags !== want.frags)
						report("fragments", got.frags, want.frags);
					if (got.culled !== want.culled)
						report("culled", got.culled, want.culled);
				end
			end
			if (in_valid && !in_stall) begin
				replies_due = {replies_due, resolve_cmd(cmd, handle, handle_valid,
					query_count, query_outcome)};
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_ENABLED) begin
					en = cfg_data[0];
				end else begin
					limit = cfg_data;
				end
			end
		end
		n_due <= replies_due.size();
	end

endmodule

[dv/tb_query_slot_allocator_top.sv]
module tb_query_slot_allocator_top import qsa_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] CMD_IGNORED     = 2'd3;
	localparam logic [1:0] OUTCOME_TIMEOUT = 2'd1;
	localparam logic [1:0] OUTCOME_LOST    = 2'd2;
	localparam logic [1:0] OUTCOME_UNKNOWN = 2'd3;
	localparam int         WATCHDOG_LIMIT  = 3000;
	localparam int         LONG_HOLD       = 400;
	localparam int         N_PHASES        = 7;
	localparam int         PHASE_ITEMS     = 200;
	localparam int         FILL_ITEMS      = 200;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [1:0]          cmd;
	logic [HANDLE_W-1:0] handle;
	logic                handle_valid;
	logic [FRAG_W-1:0]   query_count;
	logic [1:0]          query_outcome;
	logic                out_valid;
	logic                out_stall;
	logic [2:0]          status;
	logic [HANDLE_W-1:0] out_handle;
	logic                out_handle_valid;
	logic [SLOT_W-1:0]   slot;
	logic [FRAG_W-1:0]   fragments;
	logic                culled;
	logic                cfg_valid;
	logic                cfg_ready;
	logic                cfg_index;
	logic [CFG_W-1:0]    cfg_data;
	int                  fail_count;
	int                  replies_pending;

	typedef struct packed {
		logic [1:0]          c;
		logic [HANDLE_W-1:0] h;
	} sent_t;

	sent_t               sent_q [$];
	logic [HANDLE_W-1:0] live_q [$];
	bit                  send_calm = 1'b0;
	bit                  recv_calm = 1'b0;
	bit                  hold_req  = 1'b0;
	int                  quiet     = 0;

	always #1 clk = ~clk;

	query_slot_allocator_top u_dut (.*);

	query_slot_allocator_chk u_chk (.*);

	// handles known to be live, for aiming end and get at real queries
	always @(posedge clk) begin : track
		sent_t s;
		if (arst_n && out_valid && !out_stall && sent_q.size() > 0) begin
			s = sent_q.pop_front();
			if (s.c == CMD_BEGIN && out_handle_valid) begin
				live_q = {live_q, out_handle};
			end else if (s.c == CMD_GET && status == ST_OK) begin
				for (int i = 0; i < live_q.size(); i++) begin
					if (live_q[i] == s.h) begin
						live_q.delete(i);
						break;
					end
				end
			end
		end
		if (arst_n && in_valid && !in_stall) begin
			sent_q = {sent_q, sent_t'({cmd, handle})};
		end
	end

	always @(posedge clk) begin : watchdog
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else if (quiet >= WATCHDOG_LIMIT) begin
			$display("FAIL query_slot_allocator_top");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin : receiver
		int n;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
			end
			if ($urandom_range(0, 39) == 0) begin
				recv_calm = !recv_calm;
			end
			n = recv_calm ? 0 : $urandom_range(0, 16);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic send_cmd(input logic [1:0] c, input logic [HANDLE_W-1:0] h,
			input logic hv, input logic [FRAG_W-1:0] n, input logic [1:0] oc);
		int gap;
		if ($urandom_range(0, 39) == 0) begin
			send_calm = !send_calm;
		end
		gap = send_calm ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		cmd           <= c;
		handle        <= h;
		handle_valid  <= hv;
		query_count   <= n;
		query_outcome <= oc;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (replies_pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic [FRAG_W-1:0] rand_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) return '0;
		if (r < 15) return ALL_ONES;
		return $urandom;
	endfunction

	function automatic logic [1:0] rand_outcome();
		if ($urandom_range(0, 99) < 70) return OUTCOME_READY;
		return 2'($urandom_range(1, 3));
	endfunction

	task automatic send_random_cmd();
		int                  pick;
		logic [HANDLE_W-1:0] h;
		pick = $urandom_range(0, 99);
		if (live_q.size() > 0) begin
			h = live_q[$urandom_range(0, live_q.size() - 1)];
		end else begin
			h = HANDLE_W'($urandom_range(0, 15));
		end
		if (pick < 40) begin
			send_cmd(CMD_BEGIN, HANDLE_W'($urandom), 1'($urandom), $urandom, 2'($urandom));
		end else if (pick < 55) begin
			send_cmd(CMD_END, h, 1'b1, $urandom, 2'($urandom));
		end else if (pick < 85) begin
			send_cmd(CMD_GET, h, 1'b1, rand_count(), rand_outcome());
		end else if (pick < 89) begin
			send_cmd(CMD_IGNORED, HANDLE_W'($urandom), 1'($urandom), $urandom,
				2'($urandom));
		end else begin
			h = (pick < 95) ? HANDLE_W'($urandom_range(0, 63)) : HANDLE_W'($urandom);
			send_cmd(2'($urandom_range(0, 2)), h, 1'($urandom_range(0, 1)), rand_count(),
				2'($urandom));
		end
	endtask

	initial begin : stimulus
		logic                en_set  [N_PHASES];
		logic [CFG_W-1:0]    lim_set [N_PHASES];
		logic [HANDLE_W-1:0] pool [$];
		int                  k;
		int                  n_fill;
		en_set  = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
		lim_set = '{12'd2048, 12'd4, 12'd0, 12'd2048, 12'd4095, 12'd37, 12'd1};
		arst_n        <= 1'b0;
		in_valid      <= 1'b0;
		cmd           <= CMD_BEGIN;
		handle        <= '0;
		handle_valid  <= 1'b0;
		query_count   <= '0;
		query_outcome <= OUTCOME_READY;
		cfg_valid     <= 1'b0;
		cfg_index     <= CFG_ENABLED;
		cfg_data      <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: error paths, stack reuse, culled and failed gets
		send_cmd(CMD_GET, 11'd0, 1'b1, 32'h1234, OUTCOME_READY);
		send_cmd(CMD_END, 11'd2047, 1'b1, '0, OUTCOME_READY);
		send_cmd(CMD_END, 11'd2047, 1'b0, ALL_ONES, OUTCOME_UNKNOWN);
		send_cmd(CMD_GET, 11'd0, 1'b0, ALL_ONES, OUTCOME_READY);
		send_cmd(CMD_BEGIN, 11'd2047, 1'b1, ALL_ONES, OUTCOME_UNKNOWN);
		send_cmd(CMD_BEGIN, 11'd0, 1'b0, '0, OUTCOME_READY);
		send_cmd(CMD_END, 11'd0, 1'b1, '0, OUTCOME_READY);
		send_cmd(CMD_GET, 11'd0, 1'b1, '0, OUTCOME_READY);
		send_cmd(CMD_GET, 11'd0, 1'b1, 32'd7, OUTCOME_READY);
		send_cmd(CMD_BEGIN, 11'd0, 1'b0, '0, OUTCOME_READY);
		send_cmd(CMD_GET, 11'd1, 1'b1, ALL_ONES, OUTCOME_READY);
		send_cmd(CMD_BEGIN, 11'd0, 1'b0, '0, OUTCOME_READY);
		send_cmd(CMD_GET, 11'd0, 1'b1, 32'd99, OUTCOME_TIMEOUT);
		send_cmd(CMD_GET, 11'd1, 1'b1, '0, OUTCOME_LOST);
		send_cmd(CMD_BEGIN, 11'd0, 1'b0, '0, OUTCOME_READY);
		send_cmd(CMD_END, 11'd1, 1'b1, '0, OUTCOME_READY);
		send_cmd(CMD_GET, 11'd1, 1'b1, 32'd5, OUTCOME_UNKNOWN);
		send_cmd(CMD_IGNORED, 11'd2047, 1'b1, ALL_ONES, OUTCOME_UNKNOWN);
		send_cmd(CMD_BEGIN, 11'd0, 1'b0, '0, OUTCOME_READY);
		wait_idle();

		for (int p = 0; p < N_PHASES; p++) begin
			write_reg(CFG_ENABLED, CFG_W'(en_set[p]));
			write_reg(CFG_SLOT_LIMIT, lim_set[p]);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 0 && i == 60) begin
					hold_req = 1'b1;
				end
				send_random_cmd();
			end
			wait_idle();
		end

		// fill slots with 200 begins, then release every live handle in random order
		write_reg(CFG_ENABLED, 12'd1);
		write_reg(CFG_SLOT_LIMIT, CFG_W'(POOL_SIZE));
		n_fill = FILL_ITEMS;
		for (int i = 0; i < n_fill; i++) begin
			send_cmd(CMD_BEGIN, HANDLE_W'($urandom), 1'($urandom), $urandom, 2'($urandom));
		end
		wait_idle();
		pool = live_q;
		while (pool.size() > 0) begin
			k = $urandom_range(0, pool.size() - 1);
			send_cmd(CMD_GET, pool[k], 1'b1, rand_count(), rand_outcome());
			pool.delete(k);
		end
		for (int i = 0; i < 40; i++) begin
			send_random_cmd();
		end
		wait_idle();

		if (fail_count == 0 && replies_pending == 0) begin
			$display("PASS query_slot_allocator_top");
		end else begin
			$display("FAIL query_slot_allocator_top");
		end
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/qsa_pkg.sv
hw/rtl/qsa_ram.sv
hw/rtl/qsa_bitmap.sv
hw/rtl/query_slot_allocator_top.sv
dv/query_slot_allocator_chk.sv
dv/tb_query_slot_allocator_top.sv
